// ===== src/srdb_pkg.sv =====
// ----------------------------------------------------------------------------
// srdb_pkg: shared types and codes of the sequence reorder buffer
// Result codes and the result record passed between the control logic and
// the output register.
// ----------------------------------------------------------------------------
package srdb_pkg;

   localparam int KIND_W   = 2;
   localparam int SEQ_W    = 7;
   localparam int HANDLE_W = 8;

   localparam logic [KIND_W-1:0] KIND_DELIVERED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HELD      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DUP       = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT    = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } result_type;

endpackage

// ===== src/srdb_mem.sv =====
// ----------------------------------------------------------------------------
// srdb_mem: pending table storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srdb_mem #(
   parameter int DEPTH = 100,
   parameter int WIDTH = 9,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/srdb_out.sv =====
// ----------------------------------------------------------------------------
// srdb_out: response output register
// Holds one response until the consumer takes it.
// ----------------------------------------------------------------------------
module srdb_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  srdb_pkg::result_type                push_data,
   output logic                                out_free,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [srdb_pkg::KIND_W-1:0]         rsp_kind,
   output logic [srdb_pkg::SEQ_W-1:0]          rsp_out_seq,
   output logic [srdb_pkg::HANDLE_W-1:0]       rsp_out_handle,
   output logic                                rsp_last
);

   logic                 valid_ff;
   logic                 valid_in;
   srdb_pkg::result_type data_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = data_ff.kind;
   assign rsp_out_seq    = data_ff.seq;
   assign rsp_out_handle = data_ff.handle;
   assign rsp_last       = data_ff.last;

endmodule

// ===== src/sequence_reorder_dedup_buffer.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_dedup_buffer: packet reorder buffer with duplicate window
// Holds out-of-order packets in a pending table indexed by sequence id and
// releases them in strict order, dropping duplicates of pending or recently
// delivered ids.
// ----------------------------------------------------------------------------
// Each request is one arriving packet. It yields one or more responses: first
// a report (held, duplicate or rejected) unless the packet is exactly the next
// expected id, then the in-order deliveries it unblocks, at most MAX_RELEASE
// responses per request; rsp_last marks the final response of a request and a
// remaining backlog is released on the next request. All per-id state (pending
// flag and payload handle) lives in one synchronous RAM of SEQ_MODULUS words.
// After reset the block sweeps that RAM clean and holds req_ready low
// meanwhile. A request then passes accept, table lookup and close-out; the
// release walk reads one table entry per cycle through the single RAM read
// port, and back-pressure on the response channel stalls it. Only the most
// recent HISTORY_DEPTH delivered ids count as duplicates, tracked by a
// saturating count behind the last delivered id.
// ----------------------------------------------------------------------------
module sequence_reorder_dedup_buffer #(
   parameter int SEQ_MODULUS   = 100,
   parameter int HISTORY_DEPTH = 17,
   parameter int HANDLE_BITS   = 8,
   parameter int MAX_RELEASE   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_has_id,
   input  logic [srdb_pkg::SEQ_W-1:0]          req_seq_id,
   input  logic [srdb_pkg::HANDLE_W-1:0]       req_payload_handle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [srdb_pkg::KIND_W-1:0]         rsp_kind,
   output logic [srdb_pkg::SEQ_W-1:0]          rsp_out_seq,
   output logic [srdb_pkg::HANDLE_W-1:0]       rsp_out_handle,
   output logic                                rsp_last
);

   // Table index, history count and budget widths.
   localparam int IW = $clog2(SEQ_MODULUS);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int BW = $clog2(MAX_RELEASE + 1);
   localparam int DW = (IW + 1 > CW) ? IW + 1 : CW;
   // Only the handle bits that survive both the port width and HANDLE_BITS are kept.
   localparam int SW = (HANDLE_BITS < srdb_pkg::HANDLE_W) ? HANDLE_BITS : srdb_pkg::HANDLE_W;
   localparam int MW = SW + 1;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOOKUP = 3'd2;
   localparam logic [2:0] ST_CHK    = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   localparam logic [IW-1:0] LAST_ID = IW'(SEQ_MODULUS - 1);

   function automatic logic [IW-1:0] next_seq(input logic [IW-1:0] x);
      return (x == LAST_ID) ? '0 : x + 1'b1;
   endfunction

   // Control state.
   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] last_ff, last_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] bud_ff, bud_in;

   // Latched request and staged response.
   logic                 has_ff;
   logic                 idok_ff, idok_in;
   logic [srdb_pkg::SEQ_W-1:0] id_ff;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]        hdl_ff;
   srdb_pkg::result_type stage_ff, stage_in;

   // Table port.
   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [MW-1:0] mem_wdata, mem_rdata;

   // Output register port.
   logic                 push, out_free;
   srdb_pkg::result_type push_data;

   // Helper views.
   logic [IW-1:0]                    expect_id;
   logic [IW:0]                      back_gap;
   logic                             hist_dup;
   logic                             accept;
   logic [IW+srdb_pkg::SEQ_W-1:0]    req_pad;
   logic [IW+srdb_pkg::SEQ_W-1:0]    seq_pad;
   logic [IW+srdb_pkg::SEQ_W-1:0]    nx_pad;
   logic [SW+srdb_pkg::HANDLE_W-1:0] hdl_pad;
   logic [SW+srdb_pkg::HANDLE_W-1:0] rd_pad;
   logic [srdb_pkg::SEQ_W-1:0]       idx_seq;
   logic [srdb_pkg::SEQ_W-1:0]       nx_seq;
   logic [srdb_pkg::HANDLE_W-1:0]    hdl_out;
   logic [srdb_pkg::HANDLE_W-1:0]    rd_hdl_out;
   logic                             rd_valid;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign expect_id = next_seq(last_ff);
   assign rd_valid  = mem_rdata[SW];

   assign req_pad    = {{IW{1'b0}}, req_seq_id};
   assign idx_in     = req_pad[IW-1:0];
   assign idok_in    = req_has_id && (32'(req_seq_id) < 32'(SEQ_MODULUS));

   assign seq_pad    = {{srdb_pkg::SEQ_W{1'b0}}, idx_ff};
   assign idx_seq    = seq_pad[srdb_pkg::SEQ_W-1:0];
   assign hdl_pad    = {{srdb_pkg::HANDLE_W{1'b0}}, hdl_ff};
   assign hdl_out    = hdl_pad[srdb_pkg::HANDLE_W-1:0];
   assign rd_pad     = {{srdb_pkg::HANDLE_W{1'b0}}, mem_rdata[SW-1:0]};
   assign rd_hdl_out = rd_pad[srdb_pkg::HANDLE_W-1:0];

   // The id being delivered in the walk is the one after last_ff.
   assign nx_pad = {{srdb_pkg::SEQ_W{1'b0}}, expect_id};
   assign nx_seq = nx_pad[srdb_pkg::SEQ_W-1:0];

   // Distance back from the last delivered id, modulo the sequence space.
   always_comb begin
      if (last_ff >= idx_ff) begin
         back_gap = {1'b0, last_ff} - {1'b0, idx_ff};
      end else begin
         back_gap = {1'b0, last_ff} + (IW + 1)'(SEQ_MODULUS) - {1'b0, idx_ff};
      end
   end
   assign hist_dup = (DW'(back_gap) < DW'(cnt_ff));

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      last_in   = last_ff;
      cnt_in    = cnt_ff;
      bud_in    = bud_ff;
      stage_in  = stage_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = {1'b1, hdl_ff};
      mem_re    = 1'b0;
      mem_raddr = expect_id;
      push      = 1'b0;
      push_data = stage_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ID) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               mem_re    = idok_in;
               mem_raddr = idx_in;
               state_in  = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            bud_in = BW'(MAX_RELEASE - 1);
            if (idok_ff && !rd_valid && !hist_dup && idx_ff == expect_id) begin
               // The expected packet goes straight out as the first delivery.
               stage_in = '{kind: srdb_pkg::KIND_DELIVERED, seq: idx_seq,
                            handle: hdl_out, last: 1'b0};
               last_in  = idx_ff;
               if (32'(cnt_ff) < 32'(HISTORY_DEPTH)) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               mem_raddr = next_seq(idx_ff);
            end else begin
               if (!has_ff) begin
                  stage_in = '{kind: srdb_pkg::KIND_REJECT, seq: '0,
                               handle: hdl_out, last: 1'b0};
               end else if (!idok_ff) begin
                  stage_in = '{kind: srdb_pkg::KIND_REJECT, seq: id_ff,
                               handle: hdl_out, last: 1'b0};
               end else if (rd_valid || hist_dup) begin
                  stage_in = '{kind: srdb_pkg::KIND_DUP, seq: id_ff,
                               handle: hdl_out, last: 1'b0};
               end else begin
                  stage_in = '{kind: srdb_pkg::KIND_HELD, seq: id_ff,
                               handle: hdl_out, last: 1'b0};
                  mem_we   = 1'b1;
               end
               mem_raddr = expect_id;
            end
            if (MAX_RELEASE == 1) begin
               state_in = ST_FLUSH;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_CHK;
            end
         end

         ST_CHK: begin
            if (out_free) begin
               push = 1'b1;
               if (rd_valid) begin
                  push_data.last = 1'b0;
                  stage_in  = '{kind: srdb_pkg::KIND_DELIVERED, seq: nx_seq,
                                handle: rd_hdl_out, last: 1'b0};
                  mem_we    = 1'b1;
                  mem_waddr = expect_id;
                  mem_wdata = '0;
                  last_in   = expect_id;
                  if (32'(cnt_ff) < 32'(HISTORY_DEPTH)) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  bud_in = bud_ff - 1'b1;
                  if (bud_ff == BW'(1)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = next_seq(expect_id);
                  end
               end else begin
                  push_data.last = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               push           = 1'b1;
               push_data.last = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         last_ff  <= LAST_ID;
         cnt_ff   <= '0;
         bud_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         last_ff  <= last_in;
         cnt_ff   <= cnt_in;
         bud_ff   <= bud_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (accept) begin
         has_ff  <= req_has_id;
         idok_ff <= idok_in;
         id_ff   <= req_seq_id;
         idx_ff  <= idx_in;
         hdl_ff  <= req_payload_handle[SW-1:0];
      end
   end

   srdb_mem #(
      .DEPTH (SEQ_MODULUS),
      .WIDTH (MW),
      .AW    (IW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   srdb_out u_out (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .push_data      (push_data),
      .out_free       (out_free),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_out_seq    (rsp_out_seq),
      .rsp_out_handle (rsp_out_handle),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // A response is only moved into the output register when it has room.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("response pushed into a full output register");

   // The table is never read and written at the same entry in one cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("pending table read and write collide");

   // An accepted request always goes to the table lookup next.
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted request did not reach lookup");

   // The delivered history count never passes its window.
   a_hist_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(HISTORY_DEPTH))
      else $error("history count beyond window");
`endif

endmodule

// ===== test/srdb_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// srdb_scoreboard_pkg: scoreboard for the sequence reorder buffer testbench
// Predicts the responses of each accepted request from its own copy of the
// pending table and delivery history, and checks every response in order.
// ----------------------------------------------------------------------------
package srdb_scoreboard_pkg;

   localparam int SEQ_W        = srdb_pkg::SEQ_W;
   localparam int HANDLE_W     = srdb_pkg::HANDLE_W;
   localparam int SEQ_SPAN     = 100;
   localparam int RECENT_DEPTH = 17;
   localparam int RUN_CAP      = 64;
   localparam int MAX_REPORTS  = 10;
   localparam int QUEUE_DEPTH  = 1024;

   class reorder_scoreboard;

      logic [SEQ_W-1:0]     newest_out;
      bit                   parked[SEQ_SPAN];
      logic [HANDLE_W-1:0]  parked_handle[SEQ_SPAN];
      int                   recent_count;

      // Expected responses in a circular buffer, oldest at head.
      srdb_pkg::result_type awaited[QUEUE_DEPTH];
      int                   head;
      int                   waiting;

      int failures;
      int requests;
      int responses;
      int cap_hits;
      int longest_run;
      int kind_seen[4];

      function new();
         newest_out   = SEQ_W'(SEQ_SPAN - 1);
         recent_count = 0;
         head         = 0;
         waiting      = 0;
         failures     = 0;
         requests     = 0;
         responses    = 0;
         cap_hits     = 0;
         longest_run  = 0;
         foreach (parked[i]) parked[i] = 1'b0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
      endfunction

      function logic [SEQ_W-1:0] successor(logic [SEQ_W-1:0] id);
         return (int'(id) == SEQ_SPAN - 1) ? '0 : id + 1'b1;
      endfunction

      function int outstanding();
         return waiting;
      endfunction

      // Appends one expected response behind the ones already waiting.
      function void add_expected(srdb_pkg::result_type r);
         if (waiting == QUEUE_DEPTH) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("too many responses outstanding, expectation lost");
            return;
         end
         awaited[(head + waiting) % QUEUE_DEPTH] = r;
         waiting++;
      endfunction

      // Works out every response of one accepted request and queues them.
      function void note_request(bit has_id, logic [SEQ_W-1:0] seq,
                                 logic [HANDLE_W-1:0] pay);
         srdb_pkg::result_type batch[RUN_CAP];
         int                   n;
         int                   gap;
         int                   run;
         logic [SEQ_W-1:0]     nxt;
         requests++;
         n = 0;
         if (!has_id) begin
            batch[n] = '{kind: srdb_pkg::KIND_REJECT, seq: '0, handle: pay, last: 1'b0};
            n++;
         end else if (int'(seq) >= SEQ_SPAN) begin
            batch[n] = '{kind: srdb_pkg::KIND_REJECT, seq: seq, handle: pay, last: 1'b0};
            n++;
         end else begin
            // Distance behind the newest delivered id; the recent window
            // covers exactly recent_count ids ending at newest_out.
            gap = (int'(newest_out) + SEQ_SPAN - int'(seq)) % SEQ_SPAN;
            if (parked[seq] || gap < recent_count) begin
               batch[n] = '{kind: srdb_pkg::KIND_DUP, seq: seq, handle: pay, last: 1'b0};
               n++;
            end else begin
               parked[seq]        = 1'b1;
               parked_handle[seq] = pay;
               if (seq != successor(newest_out)) begin
                  batch[n] = '{kind: srdb_pkg::KIND_HELD, seq: seq, handle: pay,
                               last: 1'b0};
                  n++;
               end
            end
         end
         run = 0;
         nxt = successor(newest_out);
         while (n < RUN_CAP && parked[nxt]) begin
            batch[n] = '{kind: srdb_pkg::KIND_DELIVERED, seq: nxt,
                         handle: parked_handle[nxt], last: 1'b0};
            n++;
            parked[nxt] = 1'b0;
            newest_out  = nxt;
            if (recent_count < RECENT_DEPTH) recent_count++;
            run++;
            nxt = successor(nxt);
         end
         if (n == RUN_CAP && parked[nxt]) cap_hits++;
         if (run > longest_run) longest_run = run;
         batch[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) begin
            kind_seen[int'(batch[i].kind)]++;
            add_expected(batch[i]);
         end
      endfunction

      // Compares one accepted response with the oldest expectation.
      function void check_response(srdb_pkg::result_type got);
         srdb_pkg::result_type want;
         responses++;
         if (waiting == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("response %0d unexpected: kind %0d seq %0d handle %0d last %0d",
                        responses, got.kind, got.seq, got.handle, got.last);
            return;
         end
         want    = awaited[head];
         head    = (head + 1) % QUEUE_DEPTH;
         waiting--;
         if (got.kind !== want.kind || got.seq !== want.seq ||
             got.handle !== want.handle || got.last !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("response %0d differs: expected kind %0d seq %0d handle %0d last %0d,%s",
                        responses, want.kind, want.seq, want.handle, want.last,
                        $sformatf(" got kind %0d seq %0d handle %0d last %0d",
                                  got.kind, got.seq, got.handle, got.last));
         end
      endfunction

   endclass

endpackage

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the sequence reorder buffer with duplicate window
// Drives arriving packets through the request channel, predicts every
// response with a scoreboard and compares them in order, under random and
// deliberate back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int SEQ_W        = srdb_pkg::SEQ_W;
   localparam int HANDLE_W     = srdb_pkg::HANDLE_W;
   localparam int KIND_W       = srdb_pkg::KIND_W;
   localparam int SEQ_SPAN     = srdb_scoreboard_pkg::SEQ_SPAN;
   localparam int RECENT_DEPTH = srdb_scoreboard_pkg::RECENT_DEPTH;
   localparam int RUN_CAP      = srdb_scoreboard_pkg::RUN_CAP;

   // The receiver stalls this long once to fill the block up. The watchdog
   // allows for that, the clearing sweep after reset and random idling.
   localparam int HOLD_CYCLES   = 200;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 100;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic                req_has_id         = 1'b0;
   logic [SEQ_W-1:0]    req_seq_id         = '0;
   logic [HANDLE_W-1:0] req_payload_handle = '0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [SEQ_W-1:0]    rsp_out_seq;
   logic [HANDLE_W-1:0] rsp_out_handle;
   logic                rsp_last;

   // Idle percentages of the two sides; the stimulus changes them by phase.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Set by the stimulus to ask the receiver for one long hold-off.
   bit hold_request = 1'b0;

   // Next id the stimulus believes the block expects. It only shapes the
   // stimulus; the scoreboard keeps the real prediction.
   int next_seq = 0;

   int                                     quiet_cycles = 0;
   srdb_pkg::result_type                   seen;
   srdb_scoreboard_pkg::reorder_scoreboard sb;

   sequence_reorder_dedup_buffer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_has_id         (req_has_id),
      .req_seq_id         (req_seq_id),
      .req_payload_handle (req_payload_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_out_seq        (rsp_out_seq),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_last           (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one request. It is driven at a falling edge, possibly after a few
   // random idle cycles, and the task returns at the rising edge that
   // accepts it. Valid stays high on return; the next caller either puts a
   // new request on the port or lowers valid at the following falling edge.
   task automatic offer_packet(bit has_id, logic [SEQ_W-1:0] seq,
                               logic [HANDLE_W-1:0] pay);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid          = 1'b0;
         req_has_id         = 1'($urandom_range(1));
         req_seq_id         = SEQ_W'($urandom_range(127));
         req_payload_handle = HANDLE_W'($urandom_range(255));
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_has_id         = has_id;
      req_seq_id         = seq;
      req_payload_handle = pay;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sends well-formed runs of consecutive ids, each run shuffled so that most
   // packets are held and the last missing one releases the whole run. About
   // one request in seven is noise slipped in between: a packet with no id,
   // an id out of range, a repeat of a recently delivered id (reaching just
   // past the edge of the duplicate window) or a repeat of the run's previous id (its first id at the start).
   task automatic run_blocks(int count);
      int ids[8];
      int len;
      int j;
      int swap;
      int sent;
      int prev;
      int d;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(8, 1);
         for (int i = 0; i < len; i++) ids[i] = (next_seq + i) % SEQ_SPAN;
         for (int i = len - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            swap    = ids[i];
            ids[i]  = ids[j];
            ids[j]  = swap;
         end
         prev = -1;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 15) begin
               case ($urandom_range(3))
                  0: offer_packet(1'b0, SEQ_W'($urandom_range(127)),
                                  HANDLE_W'($urandom_range(255)));
                  1: offer_packet(1'b1, SEQ_W'($urandom_range(127, SEQ_SPAN)),
                                  HANDLE_W'($urandom_range(255)));
                  2: begin
                     d = $urandom_range(RECENT_DEPTH + 1);
                     offer_packet(1'b1, SEQ_W'((next_seq + 2 * SEQ_SPAN - 1 - d) % SEQ_SPAN),
                                  HANDLE_W'($urandom_range(255)));
                  end
                  default: offer_packet(1'b1, SEQ_W'(prev < 0 ? ids[0] : prev),
                                        HANDLE_W'($urandom_range(255)));
               endcase
               sent++;
            end
            offer_packet(1'b1, SEQ_W'(ids[i]), HANDLE_W'($urandom_range(255)));
            prev = ids[i];
            sent++;
         end
         next_seq = (next_seq + len) % SEQ_SPAN;
      end
   endtask

   // Receiver: ready changes at falling edges. A hold-off request keeps it
   // low for a fixed stretch counted here, whatever the sender is doing.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor and watchdog. Both channels are sampled at the rising edge. A
   // response is checked before a request of the same edge is noted, which
   // is safe because no request can be answered at its own acceptance edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = '{kind: rsp_kind, seq: rsp_out_seq, handle: rsp_out_handle,
                     last: rsp_last};
            sb.check_response(seen);
         end
         if (req_valid && req_ready)
            sb.note_request(req_has_id, req_seq_id, req_payload_handle);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no handshake on either channel for %0d cycles", STALL_LIMIT);
         $display("sequence_reorder_dedup_buffer: mismatch");
         $finish;
      end
   end

   initial begin
      sb = new();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed part. Packets without an id and ids out of range are
      // rejected; id 0 is the first in order. Then a duplicate of a delivered
      // id, a held packet and a duplicate of it while pending, the gap filler
      // that releases two, an id just behind the history window (held, so it
      // waits for the wrap), a reversed run released by its first id and an
      // id far ahead with the top bit of the id set.
      offer_packet(1'b0, 7'd127, 8'hFF);
      offer_packet(1'b0, 7'd0,   8'h00);
      offer_packet(1'b1, 7'd100, 8'h00);
      offer_packet(1'b1, 7'd127, 8'hAA);
      offer_packet(1'b1, 7'd0,   8'h00);
      offer_packet(1'b1, 7'd0,   8'hFF);
      offer_packet(1'b1, 7'd2,   8'hFF);
      offer_packet(1'b1, 7'd2,   8'h11);
      offer_packet(1'b1, 7'd1,   8'h55);
      offer_packet(1'b1, 7'd99,  8'h7F);
      offer_packet(1'b1, 7'd5,   8'h80);
      offer_packet(1'b1, 7'd4,   8'h01);
      offer_packet(1'b1, 7'd3,   8'hFE);
      offer_packet(1'b1, 7'd64,  8'h40);
      next_seq = 6;

      // First phase: the sender idles a quarter of the time, the receiver
      // about half.
      send_idle_pct = 25;
      recv_idle_pct = 48;
      run_blocks(45);

      // The sender pauses until every expected response has come.
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);

      // Second phase, idling the other way round. A long backlog is held
      // first, and partway through it the receiver holds off so the block
      // fills up and stalls its input. The missing head then releases the
      // capped maximum in one request, and a rejected packet carries the
      // remainder of the backlog.
      send_idle_pct = 48;
      recv_idle_pct = 25;
      for (int k = 1; k <= RUN_CAP + 2; k++) begin
         if (k == 10) hold_request = 1'b1;
         offer_packet(1'b1, SEQ_W'((next_seq + k) % SEQ_SPAN), HANDLE_W'($urandom_range(255)));
      end
      offer_packet(1'b1, SEQ_W'(next_seq), HANDLE_W'($urandom_range(255)));
      offer_packet(1'b0, SEQ_W'($urandom_range(127)), HANDLE_W'($urandom_range(255)));
      next_seq = (next_seq + RUN_CAP + 3) % SEQ_SPAN;
      run_blocks(15);

      // Last phase at full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_blocks(30);

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d packets, %0d responses: %0d delivered, %0d held, %0d duplicate, %0d rejected.",
               sb.requests, sb.responses, sb.kind_seen[srdb_pkg::KIND_DELIVERED],
               sb.kind_seen[srdb_pkg::KIND_HELD], sb.kind_seen[srdb_pkg::KIND_DUP],
               sb.kind_seen[srdb_pkg::KIND_REJECT]);
      $display("Longest release run %0d; release cap hit %0d time(s); %0d failure(s).",
               sb.longest_run, sb.cap_hits, sb.failures);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("sequence_reorder_dedup_buffer: match");
      else
         $display("sequence_reorder_dedup_buffer: mismatch");
      $finish;
   end

endmodule
